// File: hw/rtl/normal_cube_quantizer_assert.svh
// Assertion macros for the normal cube quantizer.
`ifndef NORMAL_CUBE_QUANTIZER_ASSERT_SVH
`define NORMAL_CUBE_QUANTIZER_ASSERT_SVH

// Implication checked in the same cycle.
`define NCQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle.
`define NCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/ncq_pkg.sv
// Shared types and constants of the normal cube quantizer.
package ncq_pkg;

    localparam int GRID_CELLS_DEF = 52;
    localparam int CORDIC_STEPS   = 20;
    localparam int SQRT_STEPS     = 32;
    localparam int QUEUE_DEPTH    = 4;
    localparam int WARP_ONE       = 1048576;

    localparam logic [20:0] ARC_TABLE [CORDIC_STEPS] = '{
        21'd1048576, 21'd619011, 21'd327068, 21'd166025, 21'd83335,
        21'd41708,   21'd20859,  21'd10430,  21'd5215,   21'd2608,
        21'd1304,    21'd652,    21'd326,    21'd163,    21'd81,
        21'd41,      21'd20,     21'd10,     21'd5,      21'd3
    };

    typedef enum logic [2:0] {
        FACE_POS_X = 3'd0,
        FACE_NEG_X = 3'd1,
        FACE_POS_Y = 3'd2,
        FACE_NEG_Y = 3'd3,
        FACE_POS_Z = 3'd4,
        FACE_NEG_Z = 3'd5
    } face_t;

    typedef struct packed {
        face_t              face;
        logic signed [22:0] uw;
        logic signed [22:0] vw;
        logic               use_def;
    } front_item_t;

    typedef struct packed {
        face_t              face;
        logic        [30:0] den;
        logic signed [22:0] uw;
        logic signed [22:0] vw;
    } q_item_t;

endpackage

// File: hw/rtl/ncq_front.sv
// Front end: scaled, optionally dithered sums, squared length, face select, pipelined square root.
module ncq_front #(
    parameter int GRID_CELLS = ncq_pkg::GRID_CELLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             dither_en,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [95:0]      in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output ncq_pkg::q_item_t out_item
);

    localparam logic [22:0] N_EXT   = 23'(GRID_CELLS);
    localparam logic [30:0] DEN_DEF = 31'(GRID_CELLS) << 24;
    localparam int SQRT_N = ncq_pkg::SQRT_STEPS;

    logic adv;

    logic                   v1_reg;
    logic signed [22:0]     w_reg [3];
    logic                   en1_reg;

    logic                   v2_reg;
    logic signed [45:0]     sq_reg [3];
    ncq_pkg::front_item_t   it2_reg;
    logic                   en2_reg;

    logic                   vq_reg  [SQRT_N + 1];
    logic [63:0]            sv_reg  [SQRT_N + 1];
    logic [63:0]            sr_reg  [SQRT_N + 1];
    ncq_pkg::front_item_t   itq_reg [SQRT_N + 1];

    logic signed [22:0]     w_next [3];
    logic [21:0]            ax, ay, az;
    ncq_pkg::front_item_t   it2_next;
    ncq_pkg::front_item_t   itq0_next;
    logic [47:0]            len2;

    assign adv      = !vq_reg[SQRT_N] || out_ready;
    assign in_ready = adv;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_next[i] = 23'($signed(in_data[16*i +: 16])) * $signed(N_EXT);
            if (dither_en) begin
                w_next[i] = w_next[i] + 23'($signed(in_data[48 + 16*i +: 16]));
            end
        end
    end

    always_comb begin
        ax = w_reg[0][22] ? 22'(-w_reg[0]) : w_reg[0][21:0];
        ay = w_reg[1][22] ? 22'(-w_reg[1]) : w_reg[1][21:0];
        az = w_reg[2][22] ? 22'(-w_reg[2]) : w_reg[2][21:0];
        it2_next.use_def = !en1_reg;
        if (ax > ay && ax > az) begin
            it2_next.face = (w_reg[0] > 0) ? ncq_pkg::FACE_POS_X : ncq_pkg::FACE_NEG_X;
            it2_next.uw   = w_reg[1];
            it2_next.vw   = w_reg[2];
        end else if (ax <= ay && ay > az) begin
            it2_next.face = (w_reg[1] > 0) ? ncq_pkg::FACE_POS_Y : ncq_pkg::FACE_NEG_Y;
            it2_next.uw   = w_reg[2];
            it2_next.vw   = w_reg[0];
        end else begin
            it2_next.face = (w_reg[2] > 0) ? ncq_pkg::FACE_POS_Z : ncq_pkg::FACE_NEG_Z;
            it2_next.uw   = w_reg[0];
            it2_next.vw   = w_reg[1];
        end
    end

    assign len2 = 48'(sq_reg[0]) + 48'(sq_reg[1]) + 48'(sq_reg[2]);

    always_comb begin
        itq0_next         = it2_reg;
        itq0_next.use_def = it2_reg.use_def || !en2_reg || (len2 == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            vq_reg[0] <= 1'b0;
        end else if (adv) begin
            v1_reg    <= in_valid;
            v2_reg    <= v1_reg;
            vq_reg[0] <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            w_reg   <= w_next;
            en1_reg <= dither_en;
            for (int i = 0; i < 3; i++) begin
                sq_reg[i] <= 46'(w_reg[i]) * 46'(w_reg[i]);
            end
            it2_reg <= it2_next;
            en2_reg <= en1_reg;
            sv_reg[0]  <= 64'(len2) << 18;
            sr_reg[0]  <= '0;
            itq_reg[0] <= itq0_next;
        end
    end

    for (genvar k = 0; k < SQRT_N; k++) begin : g_sqrt
        localparam logic [63:0] BIT = 64'd1 << (62 - 2*k);
        logic [63:0] trial;
        assign trial = sr_reg[k] + BIT;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vq_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vq_reg[k+1] <= vq_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                itq_reg[k+1] <= itq_reg[k];
                if (sv_reg[k] >= trial) begin
                    sv_reg[k+1] <= sv_reg[k] - trial;
                    sr_reg[k+1] <= (sr_reg[k] >> 1) + BIT;
                end else begin
                    sv_reg[k+1] <= sv_reg[k];
                    sr_reg[k+1] <= sr_reg[k] >> 1;
                end
            end
        end
    end

    assign out_valid     = vq_reg[SQRT_N];
    assign out_item.face = itq_reg[SQRT_N].face;
    assign out_item.uw   = itq_reg[SQRT_N].uw;
    assign out_item.vw   = itq_reg[SQRT_N].vw;
    assign out_item.den  = itq_reg[SQRT_N].use_def ? DEN_DEF : sr_reg[SQRT_N][30:0];

endmodule

// File: hw/rtl/ncq_queue.sv
// Short FIFO between front and back ends.
module ncq_queue (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  ncq_pkg::q_item_t push_item,
    output logic             pop_valid,
    input  logic             pop_ready,
    output ncq_pkg::q_item_t pop_item
);

    localparam int DEPTH = ncq_pkg::QUEUE_DEPTH;
    localparam int AW    = $clog2(DEPTH);
    localparam int CW    = $clog2(DEPTH + 1);

    ncq_pkg::q_item_t mem_reg [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign push_ready = cnt_reg != CW'(DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_item   = mem_reg[rd_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_next  = (do_push) ? ((wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + AW'(1)) : wr_reg;
        rd_next  = (do_pop) ? ((rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + AW'(1)) : rd_reg;
        cnt_next = cnt_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_reg] <= push_item;
        end
    end

endmodule

// File: hw/rtl/ncq_back.sv
// Back end: two CORDIC warp lanes, binning and code assembly.
module ncq_back #(
    parameter int GRID_CELLS = ncq_pkg::GRID_CELLS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  ncq_pkg::q_item_t in_item,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [2:0]       face,
    output logic [5:0]       u_bin,
    output logic [5:0]       v_bin,
    output logic [13:0]      code
);

    localparam int STEPS = ncq_pkg::CORDIC_STEPS;
    localparam logic [5:0] N6   = 6'(GRID_CELLS);
    localparam logic [5:0] NMAX = 6'(GRID_CELLS - 1);
    localparam logic signed [23:0] ONE = 24'(ncq_pkg::WARP_ONE);

    logic adv;

    logic                   vc_reg [STEPS + 1];
    logic signed [34:0]     x_reg  [STEPS + 1][2];
    logic signed [34:0]     y_reg  [STEPS + 1][2];
    logic signed [23:0]     a_reg  [STEPS + 1][2];
    logic                   neg_reg  [STEPS + 1][2];
    logic                   zero_reg [STEPS + 1][2];
    ncq_pkg::face_t         f_reg  [STEPS + 1];

    logic                   vb1_reg, vb2_reg, vb3_reg;
    logic [6:0]             b1_reg [2];
    ncq_pkg::face_t         f1_reg;
    logic [8:0]             fu2_reg;
    logic [5:0]             ub2_reg, vb2b_reg;
    ncq_pkg::face_t         f2_reg;
    logic [13:0]            code_reg;
    logic [5:0]             ub3_reg, vb3_reg_d;
    ncq_pkg::face_t         f3_reg;

    logic signed [22:0]     wl [2];
    logic signed [31:0]     nl [2];
    logic signed [23:0]     wa [2];
    logic [21:0]            pl [2];
    logic [27:0]            prod [2];
    logic [5:0]             bc [2];

    assign adv      = !vb3_reg || out_ready;
    assign in_ready = adv;

    assign wl[0] = in_item.uw;
    assign wl[1] = in_item.vw;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            nl[l] = 32'(wl[l]) <<< 9;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vc_reg[0] <= 1'b0;
        end else if (adv) begin
            vc_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_reg[0] <= in_item.face;
            for (int l = 0; l < 2; l++) begin
                x_reg[0][l]    <= 35'(in_item.den);
                y_reg[0][l]    <= nl[l][31] ? 35'(-nl[l]) : 35'(nl[l]);
                a_reg[0][l]    <= '0;
                neg_reg[0][l]  <= nl[l][31];
                zero_reg[0][l] <= nl[l] == '0;
            end
        end
    end

    for (genvar k = 0; k < STEPS; k++) begin : g_cordic
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vc_reg[k+1] <= 1'b0;
            end else if (adv) begin
                vc_reg[k+1] <= vc_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                f_reg[k+1] <= f_reg[k];
                for (int l = 0; l < 2; l++) begin
                    neg_reg[k+1][l]  <= neg_reg[k][l];
                    zero_reg[k+1][l] <= zero_reg[k][l];
                    if (!y_reg[k][l][34]) begin
                        x_reg[k+1][l] <= x_reg[k][l] + (y_reg[k][l] >>> k);
                        y_reg[k+1][l] <= y_reg[k][l] - (x_reg[k][l] >>> k);
                        a_reg[k+1][l] <= a_reg[k][l] + 24'(ncq_pkg::ARC_TABLE[k]);
                    end else begin
                        x_reg[k+1][l] <= x_reg[k][l] - (y_reg[k][l] >>> k);
                        y_reg[k+1][l] <= y_reg[k][l] + (x_reg[k][l] >>> k);
                        a_reg[k+1][l] <= a_reg[k][l] - 24'(ncq_pkg::ARC_TABLE[k]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            if (zero_reg[STEPS][l]) begin
                wa[l] = '0;
            end else if (neg_reg[STEPS][l]) begin
                wa[l] = -a_reg[STEPS][l];
            end else begin
                wa[l] = a_reg[STEPS][l];
            end
            if (wa[l] > ONE) begin
                wa[l] = ONE;
            end else if (wa[l] < -ONE) begin
                wa[l] = -ONE;
            end
            pl[l]   = 22'(wa[l] + ONE);
            prod[l] = 28'(pl[l]) * 28'(N6);
            bc[l]   = (b1_reg[l] > 7'(NMAX)) ? NMAX : b1_reg[l][5:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vb1_reg <= 1'b0;
            vb2_reg <= 1'b0;
            vb3_reg <= 1'b0;
        end else if (adv) begin
            vb1_reg <= vc_reg[STEPS];
            vb2_reg <= vb1_reg;
            vb3_reg <= vb2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f1_reg    <= f_reg[STEPS];
            b1_reg[0] <= prod[0][27:21];
            b1_reg[1] <= prod[1][27:21];
            f2_reg    <= f1_reg;
            ub2_reg   <= bc[0];
            vb2b_reg  <= bc[1];
            fu2_reg   <= 9'(f1_reg) * 9'(N6) + 9'(bc[0]);
            f3_reg    <= f2_reg;
            ub3_reg   <= ub2_reg;
            vb3_reg_d <= vb2b_reg;
            code_reg  <= 14'(14'(fu2_reg) * 14'(N6) + 14'(vb2b_reg));
        end
    end

    assign out_valid = vb3_reg;
    assign face      = f3_reg;
    assign u_bin     = ub3_reg;
    assign v_bin     = vb3_reg_d;
    assign code      = code_reg;

endmodule

// File: hw/rtl/normal_cube_quantizer.sv
// Throughput: one transfer per cycle unless m_tready stalls; front square root runs 32 stages, back CORDIC 20.
// A 4-entry queue separates front and back so each stalls on its own.
// Reset (aresetn, synchronous, active low) clears pipeline valids and queue
// pointers and sets dither_enable to 1.
module normal_cube_quantizer #(
    parameter int GRID_CELLS = ncq_pkg::GRID_CELLS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // x_component, y_component, z_component, dither_x, dither_y, dither_z
    input  logic [95:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // face, u_bin, v_bin, code, code_high, 2 zero bits, code_low, 3 zero bits
    output logic [47:0] m_tdata,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [13:0] N14 = 14'(GRID_CELLS);
    localparam logic [5:0]  N6  = 6'(GRID_CELLS);

    logic             dither_en_reg;
    logic             f_valid, f_ready, b_valid, b_ready;
    ncq_pkg::q_item_t f_item, b_item;
    logic [2:0]       face;
    logic [5:0]       u_bin, v_bin;
    logic [13:0]      code;

    assign pready = 1'b1;
    assign prdata = {31'b0, dither_en_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dither_en_reg <= 1'b1;
        end else if (psel && penable && pwrite && !paddr[2]) begin
            dither_en_reg <= pwdata[0];
        end
    end

    ncq_front #(.GRID_CELLS(GRID_CELLS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .dither_en (dither_en_reg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (s_tdata),
        .out_valid (f_valid),
        .out_ready (f_ready),
        .out_item  (f_item)
    );

    ncq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_item  (f_item),
        .pop_valid  (b_valid),
        .pop_ready  (b_ready),
        .pop_item   (b_item)
    );

    ncq_back #(.GRID_CELLS(GRID_CELLS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (b_valid),
        .in_ready  (b_ready),
        .in_item   (b_item),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .face      (face),
        .u_bin     (u_bin),
        .v_bin     (v_bin),
        .code      (code)
    );

    assign m_tdata = {3'b0, code[5:0], 2'b0, code[13:6], code, v_bin, u_bin, face};

`include "normal_cube_quantizer_assert.svh"

    `NCQ_ASSERT_NOW(a_face_range, m_tvalid, face <= 3'd5, "face out of range")
    `NCQ_ASSERT_NOW(a_bin_range, m_tvalid, (u_bin < N6) && (v_bin < N6), "bin out of range")
    `NCQ_ASSERT_NOW(a_code_sum, m_tvalid, code == (14'(face) * N14 + 14'(u_bin)) * N14 + 14'(v_bin), "code mismatch")
    `NCQ_ASSERT_NEXT(a_cfg_write, psel && penable && pwrite && !paddr[2], prdata[0] == $past(pwdata[0]), "config write lost")

endmodule
